@@ rtl/core/iag_pkg.sv @@
// im2col address generator: shared types and constants
// configuration register indexes, register file and derived geometry structs
// no dependencies
package iag_pkg;

   // configuration register indexes
   localparam logic [3:0] REG_IMAGE_ROWS  = 4'd0;
   localparam logic [3:0] REG_IMAGE_COLS  = 4'd1;
   localparam logic [3:0] REG_KERNEL_ROWS = 4'd2;
   localparam logic [3:0] REG_KERNEL_COLS = 4'd3;
   localparam logic [3:0] REG_ROW_STRIDE  = 4'd4;
   localparam logic [3:0] REG_COL_STRIDE  = 4'd5;
   localparam logic [3:0] REG_ROW_PAD     = 4'd6;
   localparam logic [3:0] REG_COL_PAD     = 4'd7;

   // raw configuration registers
   typedef struct packed {
      logic [10:0] image_rows;
      logic [10:0] image_cols;
      logic [4:0]  kernel_rows;
      logic [4:0]  kernel_cols;
      logic [4:0]  row_stride;
      logic [4:0]  col_stride;
      logic [3:0]  row_pad;
      logic [3:0]  col_pad;
   } cfg_type;

   // geometry derived from the registers, held until the next write
   typedef struct packed {
      logic [4:0]  kr;         // kernel rows, zero taken as one
      logic [4:0]  kc;         // kernel columns, zero taken as one
      logic [4:0]  rs;         // row stride, zero taken as one
      logic [4:0]  cs;         // column stride, zero taken as one
      logic [11:0] ocols;      // placements per output row
      logic [23:0] per_img;    // placements per image
      logic [9:0]  per_chan;   // patch columns per channel
      logic [31:0] recip_oc;   // floor((2^32-1) / ocols)
      logic [15:0] recip_pc;   // floor((2^16-1) / per_chan)
      logic [15:0] recip_kc;   // floor((2^16-1) / kc)
   } geom_type;

   function automatic logic [4:0] at_least_one(input logic [4:0] v);
      return (v == 5'd0) ? 5'd1 : v;
   endfunction

endpackage

@@ rtl/core/iag_csr.sv @@
// im2col address generator: configuration register file
// holds the eight geometry registers written over the csr channel
// depends on iag_pkg
module iag_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [3:0]        wr_index,
   input  logic [10:0]       wr_data,
   output iag_pkg::cfg_type  cfg
);

   iag_pkg::cfg_type cfg_ff;
   iag_pkg::cfg_type cfg_in;

   // register write decode, indexes beyond the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            iag_pkg::REG_IMAGE_ROWS:  cfg_in.image_rows  = wr_data;
            iag_pkg::REG_IMAGE_COLS:  cfg_in.image_cols  = wr_data;
            iag_pkg::REG_KERNEL_ROWS: cfg_in.kernel_rows = wr_data[4:0];
            iag_pkg::REG_KERNEL_COLS: cfg_in.kernel_cols = wr_data[4:0];
            iag_pkg::REG_ROW_STRIDE:  cfg_in.row_stride  = wr_data[4:0];
            iag_pkg::REG_COL_STRIDE:  cfg_in.col_stride  = wr_data[4:0];
            iag_pkg::REG_ROW_PAD:     cfg_in.row_pad     = wr_data[3:0];
            iag_pkg::REG_COL_PAD:     cfg_in.col_pad     = wr_data[3:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_rows  <= 11'd1;
         cfg_ff.image_cols  <= 11'd1;
         cfg_ff.kernel_rows <= 5'd1;
         cfg_ff.kernel_cols <= 5'd1;
         cfg_ff.row_stride  <= 5'd1;
         cfg_ff.col_stride  <= 5'd1;
         cfg_ff.row_pad     <= 4'd0;
         cfg_ff.col_pad     <= 4'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/iag_setup.sv @@
// im2col address generator: geometry setup sequencer
// derives grid size and reciprocals with one shared radix-2 divider after each write
// depends on iag_pkg
module iag_setup (
   input  logic               clock,
   input  logic               reset,
   input  iag_pkg::cfg_type   cfg,
   input  logic               restart,
   output iag_pkg::geom_type  geom,
   output logic               busy
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_STORE = 2'd3;

   localparam logic [2:0] OP_ROWS     = 3'd0;
   localparam logic [2:0] OP_COLS     = 3'd1;
   localparam logic [2:0] OP_RECIP_OC = 3'd2;
   localparam logic [2:0] OP_RECIP_PC = 3'd3;
   localparam logic [2:0] OP_RECIP_KC = 3'd4;

   localparam logic [4:0]  LAST_STEP = 5'd31;
   localparam logic [31:0] ONES_32   = 32'hFFFF_FFFF;
   localparam logic [31:0] ONES_16   = 32'h0000_FFFF;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [4:0]  step_ff, step_in;
   logic [11:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [11:0] dvs_ff, dvs_in;
   logic [11:0] orows_ff, orows_in;
   logic [11:0] ocols_ff, ocols_in;
   logic [23:0] per_img_ff, per_img_in;
   logic [9:0]  per_chan_ff, per_chan_in;
   logic [31:0] recip_oc_ff, recip_oc_in;
   logic [15:0] recip_pc_ff, recip_pc_in;
   logic [15:0] recip_kc_ff, recip_kc_in;

   logic [4:0]  kr, kc, rs, cs;
   logic [11:0] padded_r, padded_c, span_r, span_c;
   logic [31:0] dividend;
   logic [11:0] divisor;
   logic [12:0] trial;
   logic        trial_ge;
   logic [11:0] rem_next;

   // effective kernel and stride sizes
   assign kr = iag_pkg::at_least_one(cfg.kernel_rows);
   assign kc = iag_pkg::at_least_one(cfg.kernel_cols);
   assign rs = iag_pkg::at_least_one(cfg.row_stride);
   assign cs = iag_pkg::at_least_one(cfg.col_stride);

   // span of kernel placements over the padded image, zero if the kernel overhangs
   assign padded_r = {1'b0, cfg.image_rows} + {7'd0, cfg.row_pad, 1'b0};
   assign padded_c = {1'b0, cfg.image_cols} + {7'd0, cfg.col_pad, 1'b0};
   assign span_r   = (padded_r >= {7'd0, kr}) ? padded_r - {7'd0, kr} : 12'd0;
   assign span_c   = (padded_c >= {7'd0, kc}) ? padded_c - {7'd0, kc} : 12'd0;

   // operand select for the current division
   always_comb begin
      case (op_ff)
         OP_ROWS: begin
            dividend = {20'd0, span_r};
            divisor  = {7'd0, rs};
         end
         OP_COLS: begin
            dividend = {20'd0, span_c};
            divisor  = {7'd0, cs};
         end
         OP_RECIP_OC: begin
            dividend = ONES_32;
            divisor  = ocols_ff;
         end
         OP_RECIP_PC: begin
            dividend = ONES_16;
            divisor  = {2'd0, per_chan_ff};
         end
         OP_RECIP_KC: begin
            dividend = ONES_16;
            divisor  = {7'd0, kc};
         end
         default: begin
            dividend = ONES_16;
            divisor  = 12'd1;
         end
      endcase
   end

   // one restoring division step
   assign trial    = {rem_ff, quo_ff[31]};
   assign trial_ge = trial >= {1'b0, dvs_ff};
   assign rem_next = trial_ge ? 12'(trial - {1'b0, dvs_ff}) : trial[11:0];

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      step_in     = step_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvs_in      = dvs_ff;
      orows_in    = orows_ff;
      ocols_in    = ocols_ff;
      per_img_in  = per_img_ff;
      per_chan_in = per_chan_ff;
      recip_oc_in = recip_oc_ff;
      recip_pc_in = recip_pc_ff;
      recip_kc_in = recip_kc_ff;
      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            rem_in   = 12'd0;
            quo_in   = dividend;
            dvs_in   = divisor;
            step_in  = 5'd0;
            state_in = ST_RUN;
            if (op_ff == OP_ROWS) begin
               per_chan_in = {5'd0, kr} * {5'd0, kc};
            end
         end
         ST_RUN: begin
            rem_in  = rem_next;
            quo_in  = {quo_ff[30:0], trial_ge};
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            case (op_ff)
               OP_ROWS:     orows_in = quo_ff[11:0] + 12'd1;
               OP_COLS:     ocols_in = quo_ff[11:0] + 12'd1;
               OP_RECIP_OC: begin
                  recip_oc_in = quo_ff;
                  per_img_in  = {12'd0, orows_ff} * {12'd0, ocols_ff};
               end
               OP_RECIP_PC: recip_pc_in = quo_ff[15:0];
               OP_RECIP_KC: recip_kc_in = quo_ff[15:0];
               default:     recip_kc_in = recip_kc_ff;
            endcase
            if (op_ff == OP_RECIP_KC) begin
               state_in = ST_IDLE;
            end else begin
               op_in    = op_ff + 3'd1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // a register write starts the whole derivation again
      if (restart) begin
         state_in = ST_LOAD;
         op_in    = OP_ROWS;
      end
   end

   // control and derived geometry
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         op_ff       <= OP_ROWS;
         orows_ff    <= 12'd1;
         ocols_ff    <= 12'd1;
         per_img_ff  <= 24'd1;
         per_chan_ff <= 10'd1;
         recip_oc_ff <= ONES_32;
         recip_pc_ff <= ONES_16[15:0];
         recip_kc_ff <= ONES_16[15:0];
      end else begin
         state_ff    <= state_in;
         op_ff       <= op_in;
         orows_ff    <= orows_in;
         ocols_ff    <= ocols_in;
         per_img_ff  <= per_img_in;
         per_chan_ff <= per_chan_in;
         recip_oc_ff <= recip_oc_in;
         recip_pc_ff <= recip_pc_in;
         recip_kc_ff <= recip_kc_in;
      end
   end

   // divider working registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign busy = (state_ff != ST_IDLE);

   assign geom.kr       = kr;
   assign geom.kc       = kc;
   assign geom.rs       = rs;
   assign geom.cs       = cs;
   assign geom.ocols    = ocols_ff;
   assign geom.per_img  = per_img_ff;
   assign geom.per_chan = per_chan_ff;
   assign geom.recip_oc = recip_oc_ff;
   assign geom.recip_pc = recip_pc_ff;
   assign geom.recip_kc = recip_kc_ff;

endmodule

@@ rtl/core/iag_pipe.sv @@
// im2col address generator: seven-stage address datapath
// splits position and patch column by reciprocal multiply and forms the source pixel
// depends on iag_pkg
module iag_pipe #(
   parameter int CHANNELS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_fire,
   input  logic [7:0]         batch_index,
   input  logic [19:0]        out_position,
   input  logic [9:0]         patch_column,
   input  iag_pkg::cfg_type   cfg,
   input  iag_pkg::geom_type  geom,
   output logic               out_valid,
   output logic [27:0]        patch_row,
   output logic [19:0]        pixel_index,
   output logic [9:0]         source_column,
   output logic               in_bounds
);

   localparam logic [9:0] CHANNELS_W = 10'(CHANNELS);

   logic [7:1] valid_ff;

   // stage 1: quotient estimates and batch offset
   logic [7:0]  s1_batch_ff;
   logic [19:0] s1_pos_ff;
   logic [9:0]  s1_col_ff;
   logic [19:0] s1_qpos_ff;
   logic [9:0]  s1_qch_ff;
   logic [27:0] s1_bimg_ff;
   logic [51:0] prod_pos;
   logic [25:0] prod_col;
   logic [31:0] prod_bimg;

   assign prod_pos  = 52'(out_position) * 52'(geom.recip_oc);
   assign prod_col  = 26'(patch_column) * 26'(geom.recip_pc);
   assign prod_bimg = 32'(batch_index) * 32'(geom.per_img);

   // stage 2: remainders of the estimates, patch row
   logic [7:0]  s2_batch_ff;
   logic [19:0] s2_qpos_ff;
   logic [9:0]  s2_qch_ff;
   logic [12:0] s2_rem_p_ff;
   logic [10:0] s2_rem_c_ff;
   logic [27:0] s2_prow_ff;
   logic [31:0] diff_pos;
   logic [19:0] diff_col;

   assign diff_pos = 32'(s1_pos_ff) - 32'(s1_qpos_ff) * 32'(geom.ocols);
   assign diff_col = 20'(s1_col_ff) - 20'(s1_qch_ff) * 20'(geom.per_chan);

   // stage 3: quotient correction
   logic [7:0]  s3_batch_ff;
   logic [19:0] s3_prow_ff;
   logic [11:0] s3_pcol_ff;
   logic [9:0]  s3_chan_ff;
   logic [9:0]  s3_within_ff;
   logic [27:0] s3_patch_ff;
   logic        ge_pos, ge_col;
   logic [19:0] prow_in;
   logic [11:0] pcol_in;
   logic [9:0]  chan_in;
   logic [9:0]  within_in;

   assign ge_pos    = s2_rem_p_ff >= {1'b0, geom.ocols};
   assign ge_col    = s2_rem_c_ff >= {1'b0, geom.per_chan};
   assign prow_in   = s2_qpos_ff + 20'(ge_pos);
   assign pcol_in   = ge_pos ? 12'(s2_rem_p_ff - {1'b0, geom.ocols}) : s2_rem_p_ff[11:0];
   assign chan_in   = s2_qch_ff + 10'(ge_col);
   assign within_in = ge_col ? 10'(s2_rem_c_ff - {1'b0, geom.per_chan}) : s2_rem_c_ff[9:0];

   // stage 4: kernel row estimate, placement offsets, source column
   logic [9:0]  s4_within_ff;
   logic [9:0]  s4_kq_ff;
   logic [24:0] s4_rprod_ff;
   logic [16:0] s4_cprod_ff;
   logic [9:0]  s4_src_ff;
   logic [27:0] s4_patch_ff;
   logic [25:0] prod_kc;

   assign prod_kc = 26'(s3_within_ff) * 26'(geom.recip_kc);

   // stage 5: kernel remainder, padded base coordinates
   logic [9:0]         s5_kq_ff;
   logic [5:0]         s5_rem_k_ff;
   logic signed [26:0] s5_rbase_ff;
   logic signed [18:0] s5_cbase_ff;
   logic [9:0]         s5_src_ff;
   logic [27:0]        s5_patch_ff;
   logic [14:0]        diff_k;

   assign diff_k = 15'(s4_within_ff) - 15'(s4_kq_ff) * 15'(geom.kc);

   // stage 6: kernel index correction, source coordinates
   logic signed [26:0] s6_r_ff;
   logic signed [18:0] s6_c_ff;
   logic [9:0]         s6_src_ff;
   logic [27:0]        s6_patch_ff;
   logic               ge_k;
   logic [4:0]         krow_idx, kcol_idx;

   assign ge_k     = s5_rem_k_ff >= {1'b0, geom.kc};
   assign krow_idx = 5'(s5_kq_ff + 10'(ge_k));
   assign kcol_idx = ge_k ? 5'(s5_rem_k_ff - {1'b0, geom.kc}) : s5_rem_k_ff[4:0];

   // stage 7: bounds check and flat pixel index
   logic [27:0] s7_patch_ff;
   logic [19:0] s7_pixel_ff;
   logic [9:0]  s7_src_ff;
   logic        s7_inside_ff;
   logic        r_ok, c_ok, pix_in_image;
   logic [21:0] pix;

   assign r_ok         = !s6_r_ff[26] && (s6_r_ff[25:0] < 26'(cfg.image_rows));
   assign c_ok         = !s6_c_ff[18] && (s6_c_ff[17:0] < 18'(cfg.image_cols));
   assign pix_in_image = r_ok && c_ok;
   assign pix          = 22'(s6_r_ff[10:0]) * 22'(cfg.image_cols) + 22'(s6_c_ff[10:0]);

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[6:1], in_fire};
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_batch_ff  <= batch_index;
         s1_pos_ff    <= out_position;
         s1_col_ff    <= patch_column;
         s1_qpos_ff   <= prod_pos[51:32];
         s1_qch_ff    <= prod_col[25:16];
         s1_bimg_ff   <= prod_bimg[27:0];

         s2_batch_ff  <= s1_batch_ff;
         s2_qpos_ff   <= s1_qpos_ff;
         s2_qch_ff    <= s1_qch_ff;
         s2_rem_p_ff  <= diff_pos[12:0];
         s2_rem_c_ff  <= diff_col[10:0];
         s2_prow_ff   <= s1_bimg_ff + 28'(s1_pos_ff);

         s3_batch_ff  <= s2_batch_ff;
         s3_prow_ff   <= prow_in;
         s3_pcol_ff   <= pcol_in;
         s3_chan_ff   <= chan_in;
         s3_within_ff <= within_in;
         s3_patch_ff  <= s2_prow_ff;

         s4_within_ff <= s3_within_ff;
         s4_kq_ff     <= prod_kc[25:16];
         s4_rprod_ff  <= 25'(s3_prow_ff) * 25'(geom.rs);
         s4_cprod_ff  <= 17'(s3_pcol_ff) * 17'(geom.cs);
         s4_src_ff    <= 10'(s3_batch_ff) * CHANNELS_W + s3_chan_ff;
         s4_patch_ff  <= s3_patch_ff;

         s5_kq_ff     <= s4_kq_ff;
         s5_rem_k_ff  <= diff_k[5:0];
         s5_rbase_ff  <= $signed({2'b00, s4_rprod_ff}) - $signed({23'd0, cfg.row_pad});
         s5_cbase_ff  <= $signed({2'b00, s4_cprod_ff}) - $signed({15'd0, cfg.col_pad});
         s5_src_ff    <= s4_src_ff;
         s5_patch_ff  <= s4_patch_ff;

         s6_r_ff      <= s5_rbase_ff + $signed({22'd0, krow_idx});
         s6_c_ff      <= s5_cbase_ff + $signed({14'd0, kcol_idx});
         s6_src_ff    <= s5_src_ff;
         s6_patch_ff  <= s5_patch_ff;

         s7_patch_ff  <= s6_patch_ff;
         s7_pixel_ff  <= pix_in_image ? pix[19:0] : 20'd0;
         s7_src_ff    <= s6_src_ff;
         s7_inside_ff <= pix_in_image;
      end
   end

   assign out_valid     = valid_ff[7];
   assign patch_row     = s7_patch_ff;
   assign pixel_index   = s7_pixel_ff;
   assign source_column = s7_src_ff;
   assign in_bounds     = s7_inside_ff;

endmodule

@@ rtl/core/im2col_address_generator.sv @@
// im2col address generator: top level
// joins the register file, the geometry setup sequencer and the address pipeline
// depends on iag_pkg, iag_csr, iag_setup, iag_pipe
//
// Each request transfer (batch index, kernel placement, patch column) yields one
// response transfer: patch-matrix row, flat source pixel index, source column and
// an in-bounds flag that is low where the element falls on padding (pixel index 0).
// Geometry registers are written over the csr channel, which is always ready.
// After every register write a sequencer derives the output grid width, the
// placements per image and three reciprocals with one radix-2 divider: five
// divisions of 32 steps plus load and store, during which req_stall is held
// high. Reset loads the default geometry directly, so requests are taken from
// the first cycle after reset with no setup pass.
// A request passes through the seven register stages of the datapath, each
// holding at most one multiply followed by adds or compares on any path; the
// pipeline takes one request per cycle while req_stall is low. When rsp_stall is
// high while a response is waiting, the whole pipeline holds and req_stall rises
// in the same cycle; nothing is lost or repeated.
module im2col_address_generator #(
   parameter int CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_batch_index,
   input  logic [19:0] req_out_position,
   input  logic [9:0]  req_patch_column,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [27:0] rsp_patch_row,
   output logic [19:0] rsp_pixel_index,
   output logic [9:0]  rsp_source_column,
   output logic        rsp_in_bounds,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [10:0] csr_data
);

   iag_pkg::cfg_type  cfg;
   iag_pkg::geom_type geom;
   logic              csr_write;
   logic              setup_busy;
   logic              advance;
   logic              in_fire;

   // handshake: the pipeline moves unless a finished response is held back
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance || setup_busy;
   assign in_fire   = req_valid && !req_stall;

   iag_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_write),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   iag_setup u_setup (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .restart (csr_write),
      .geom    (geom),
      .busy    (setup_busy)
   );

   iag_pipe #(
      .CHANNELS (CHANNELS)
   ) u_pipe (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_fire       (in_fire),
      .batch_index   (req_batch_index),
      .out_position  (req_out_position),
      .patch_column  (req_patch_column),
      .cfg           (cfg),
      .geom          (geom),
      .out_valid     (rsp_valid),
      .patch_row     (rsp_patch_row),
      .pixel_index   (rsp_pixel_index),
      .source_column (rsp_source_column),
      .in_bounds     (rsp_in_bounds)
   );

endmodule

@@ bench/im2col_address_generator_tb.sv @@
// testbench for the im2col address generator: directed and random request streams
// checked against a built-in predictor; depends on iag_pkg and im2col_address_generator
`timescale 1ns / 100ps

module im2col_address_generator_tb;

   localparam int CHANNELS = 4;
   localparam int PIPE_LATENCY = 7;
   localparam logic [3:0] REG_FIRST_UNUSED = 4'd8;
   localparam logic [3:0] REG_LAST_UNUSED  = 4'd15;

   // one response transfer as the block should produce it
   typedef struct {
      logic [27:0] patch_row;
      logic [19:0] pixel_index;
      logic [9:0]  source_column;
      logic        in_bounds;
   } addr_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_batch_index = '0;
   logic [19:0] req_out_position = '0;
   logic [9:0]  req_patch_column = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [27:0] rsp_patch_row;
   logic [19:0] rsp_pixel_index;
   logic [9:0]  rsp_source_column;
   logic        rsp_in_bounds;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [10:0] csr_data = '0;

   iag_pkg::cfg_type geometry;
   addr_result_type  expected_addresses[$];
   addr_result_type  oldest;
   int               error_count = 0;
   int               stall_run = 0;
   int               stall_len;
   bit               steady_flow = 1'b0;

   im2col_address_generator #(.CHANNELS(CHANNELS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_batch_index(req_batch_index), .req_out_position(req_out_position),
      .req_patch_column(req_patch_column),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_patch_row(rsp_patch_row), .rsp_pixel_index(rsp_pixel_index),
      .rsp_source_column(rsp_source_column), .rsp_in_bounds(rsp_in_bounds),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      if (steady_flow) return 0;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // placements along one axis; a kernel wider than the padded image leaves one
   function automatic longint unsigned placement_count(input longint unsigned img,
         input longint unsigned pad, input longint unsigned ker,
         input longint unsigned stride);
      longint unsigned padded;
      padded = img + 2 * pad;
      return ((padded >= ker) ? padded - ker : 0) / stride + 1;
   endfunction

   // source of one patch-matrix element under the current geometry
   function automatic addr_result_type map_patch_element(input logic [7:0] batch,
         input logic [19:0] pos, input logic [9:0] column);
      longint unsigned kr, kc, rs, cs, orows, ocols, per_chan, kernel_offset, prow, pcol;
      longint unsigned channel;
      longint r, c, img_r, img_c, pad_r, pad_c;
      bit in_image;
      addr_result_type res;
      // zero sizes and strides count as one
      kr = (geometry.kernel_rows == 0) ? 1 : geometry.kernel_rows;
      kc = (geometry.kernel_cols == 0) ? 1 : geometry.kernel_cols;
      rs = (geometry.row_stride == 0) ? 1 : geometry.row_stride;
      cs = (geometry.col_stride == 0) ? 1 : geometry.col_stride;
      orows = placement_count(geometry.image_rows, geometry.row_pad, kr, rs);
      ocols = placement_count(geometry.image_cols, geometry.col_pad, kc, cs);
      per_chan = kr * kc;
      channel = column / per_chan;
      kernel_offset = column % per_chan;
      prow = pos / ocols;
      pcol = pos % ocols;
      img_r = geometry.image_rows;
      img_c = geometry.image_cols;
      pad_r = geometry.row_pad;
      pad_c = geometry.col_pad;
      r = prow * rs;
      r = r - pad_r + longint'(kernel_offset / kc);
      c = pcol * cs;
      c = c - pad_c + longint'(kernel_offset % kc);
      in_image = (r >= 0) && (r < img_r) && (c >= 0) && (c < img_c);
      res.patch_row = 28'(longint'(batch) * orows * ocols + pos);
      res.pixel_index = in_image ? 20'(r * img_c + c) : 20'd0;
      res.source_column = 10'(longint'(batch) * CHANNELS + channel);
      res.in_bounds = in_image;
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // request transfer, with a random idle stretch in front
   task automatic send_request(input logic [7:0] batch, input logic [19:0] pos,
         input logic [9:0] column);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_batch_index <= batch;
      req_out_position <= pos;
      req_patch_column <= column;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_addresses.push_back(map_patch_element(batch, pos, column));
   endtask

   // stop requesting and let every outstanding response come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_addresses.size() != 0) @(posedge clock);
   endtask

   // one register write transfer; the local copy follows at the same edge
   task automatic write_register(input logic [3:0] idx, input logic [10:0] data);
      int gap;
      gap = pick_gap();
      repeat (gap) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         iag_pkg::REG_IMAGE_ROWS:  geometry.image_rows = data;
         iag_pkg::REG_IMAGE_COLS:  geometry.image_cols = data;
         iag_pkg::REG_KERNEL_ROWS: geometry.kernel_rows = data[4:0];
         iag_pkg::REG_KERNEL_COLS: geometry.kernel_cols = data[4:0];
         iag_pkg::REG_ROW_STRIDE:  geometry.row_stride = data[4:0];
         iag_pkg::REG_COL_STRIDE:  geometry.col_stride = data[4:0];
         iag_pkg::REG_ROW_PAD:     geometry.row_pad = data[3:0];
         iag_pkg::REG_COL_PAD:     geometry.col_pad = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // full geometry, written only once the pipeline is empty;
   // unused upper data bits of the narrow registers carry noise
   task automatic write_geometry(input int rows, input int cols, input int kr,
         input int kc, input int rs, input int cs, input int rp, input int cp);
      wait_for_drain();
      write_register(iag_pkg::REG_IMAGE_ROWS, 11'(rows));
      write_register(iag_pkg::REG_IMAGE_COLS, 11'(cols));
      write_register(iag_pkg::REG_KERNEL_ROWS, {6'($urandom), 5'(kr)});
      write_register(iag_pkg::REG_KERNEL_COLS, {6'($urandom), 5'(kc)});
      write_register(iag_pkg::REG_ROW_STRIDE, {6'($urandom), 5'(rs)});
      write_register(iag_pkg::REG_COL_STRIDE, {6'($urandom), 5'(cs)});
      write_register(iag_pkg::REG_ROW_PAD, {7'($urandom), 4'(rp)});
      write_register(iag_pkg::REG_COL_PAD, {7'($urandom), 4'(cp)});
   endtask

   // reset geometry, including position and column far out of range
   task automatic test_default_geometry();
      send_request(8'd0, 20'd0, 10'd0);
      send_request(8'hFF, 20'hFFFFF, 10'h3FF);
      send_request(8'h80, 20'd1, 10'd3);
   endtask

   // corners of a padded grid, strided rows, first and last channel
   task automatic test_padding_borders();
      write_geometry(5, 7, 3, 3, 2, 1, 1, 2);
      send_request(8'd0, 20'd0, 10'd0);
      send_request(8'hFF, 20'd26, 10'd35);
      send_request(8'd3, 20'd13, 10'd4);
      send_request(8'd1, 20'd8, 10'd2);
      send_request(8'd7, 20'd18, 10'd24);
   endtask

   // zero kernel and stride, empty image, kernel wider than the padded image
   task automatic test_degenerate_registers();
      write_geometry(6, 6, 0, 0, 0, 0, 0, 0);
      send_request(8'd2, 20'd0, 10'd0);
      send_request(8'd5, 20'd35, 10'd3);
      send_request(8'd9, 20'd17, 10'd2);
      write_geometry(0, 0, 3, 3, 1, 1, 1, 1);
      send_request(8'd1, 20'd0, 10'd4);
      send_request(8'd4, 20'd0, 10'd35);
      write_geometry(2, 3, 16, 16, 1, 1, 0, 0);
      send_request(8'd0, 20'd0, 10'd0);
      send_request(8'd6, 20'd0, 10'd1023);
   endtask

   // writes to indexes past the last register change nothing
   task automatic test_unused_register_index();
      wait_for_drain();
      write_register(REG_FIRST_UNUSED, 11'h7FF);
      write_register(REG_LAST_UNUSED, 11'h555);
      send_request(8'd3, 20'd0, 10'd17);
      send_request(8'd8, 20'd0, 10'd300);
   endtask

   // widest image field, kernel and stride of 16, biggest pad
   task automatic test_largest_geometry();
      write_geometry(2047, 2047, 16, 16, 16, 16, 15, 15);
      send_request(8'hFF, 20'd16383, 10'd1023);
      send_request(8'd0, 20'd127, 10'd255);
      write_geometry(2047, 2047, 1, 1, 1, 1, 15, 15);
      send_request(8'hFF, 20'hFFFFF, 10'd3);
      send_request(8'h55, 20'hAAAAA, 10'd2);
   endtask

   function automatic int random_image_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(40, 1);
      if (roll < 90) return $urandom_range(1024, 41);
      if (roll < 96) return $urandom_range(2047, 1025);
      return 0;
   endfunction

   function automatic int random_kernel(input int padded);
      if ($urandom_range(99) < 5) return 0;
      return $urandom_range((padded < 1) ? 1 : (padded > 16) ? 16 : padded, 1);
   endfunction

   function automatic int random_stride();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return 0;
      if (roll < 75) return $urandom_range(4, 1);
      return $urandom_range(16, 1);
   endfunction

   // phase 0 and 1 take the in-range extremes, the rest are drawn at random
   task automatic write_random_geometry(input int phase);
      int rows, cols, rp, cp;
      if (phase == 0) begin
         write_geometry(1024, 1024, 16, 16, 16, 16, 15, 15);
      end else if (phase == 1) begin
         write_geometry(1, 1, 1, 1, 1, 1, 0, 0);
      end else begin
         rows = random_image_size();
         cols = random_image_size();
         rp = $urandom_range(99) < 30 ? 0 : $urandom_range(15);
         cp = $urandom_range(99) < 30 ? 0 : $urandom_range(15);
         write_geometry(rows, cols, random_kernel(rows + 2 * rp), random_kernel(cols + 2 * cp),
                        random_stride(), random_stride(), rp, cp);
      end
   endtask

   // mostly in-range elements, with grid edges favoured; the rest raw noise
   task automatic send_random_item();
      longint unsigned kr, kc, per_img, columns, pos;
      int roll;
      kr = (geometry.kernel_rows == 0) ? 1 : geometry.kernel_rows;
      kc = (geometry.kernel_cols == 0) ? 1 : geometry.kernel_cols;
      per_img = placement_count(geometry.image_rows, geometry.row_pad, kr,
                   (geometry.row_stride == 0) ? 1 : geometry.row_stride)
              * placement_count(geometry.image_cols, geometry.col_pad, kc,
                   (geometry.col_stride == 0) ? 1 : geometry.col_stride);
      if (per_img > 20'hFFFFF + 1) per_img = 20'hFFFFF + 1;
      columns = CHANNELS * kr * kc;
      if (columns > 1024) columns = 1024;
      roll = $urandom_range(99);
      if (roll < 80) begin
         pos = $urandom_range(32'(per_img - 1), 0);
         if (roll < 8) pos = 0;
         else if (roll < 16) pos = per_img - 1;
         send_request(8'($urandom), 20'(pos), 10'($urandom_range(32'(columns - 1), 0)));
      end else begin
         send_request(8'($urandom), 20'($urandom), 10'($urandom));
      end
   endtask

   task automatic test_random_geometries();
      for (int phase = 0; phase < 10; phase++) begin
         write_random_geometry(phase);
         steady_flow = (phase == 3) || (phase == 7);
         repeat (145) send_random_item();
         steady_flow = 1'b0;
      end
   endtask

   // response side stall: alternating free and held runs
   always @(negedge clock) begin
      if (steady_flow) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run != 0) begin
         stall_run--;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_run = $urandom_range(6);
      end else begin
         stall_len = pick_gap();
         if (stall_len != 0) begin
            rsp_stall <= 1'b1;
            stall_run = stall_len - 1;
         end
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_addresses.size() == 0) begin
            report_error($sformatf("response with nothing pending, patch_row %0h",
                                   rsp_patch_row));
         end else begin
            oldest = expected_addresses.pop_front();
            if (rsp_patch_row !== oldest.patch_row)
               report_error($sformatf("patch_row %0h, expected %0h",
                                      rsp_patch_row, oldest.patch_row));
            if (rsp_pixel_index !== oldest.pixel_index)
               report_error($sformatf("pixel_index %0h, expected %0h",
                                      rsp_pixel_index, oldest.pixel_index));
            if (rsp_source_column !== oldest.source_column)
               report_error($sformatf("source_column %0h, expected %0h",
                                      rsp_source_column, oldest.source_column));
            if (rsp_in_bounds !== oldest.in_bounds)
               report_error($sformatf("in_bounds %0b, expected %0b",
                                      rsp_in_bounds, oldest.in_bounds));
         end
      end
   end

   initial begin
      geometry = '{image_rows: 11'd1, image_cols: 11'd1, kernel_rows: 5'd1,
                   kernel_cols: 5'd1, row_stride: 5'd1, col_stride: 5'd1,
                   row_pad: 4'd0, col_pad: 4'd0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_geometry();
      test_padding_borders();
      test_degenerate_registers();
      test_unused_register_index();
      test_largest_geometry();
      test_random_geometries();

      // catch any stray response after the last expected one
      wait_for_drain();
      repeat (4 * PIPE_LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(64'd12_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/iag_pkg.sv
rtl/core/iag_csr.sv
rtl/core/iag_setup.sv
rtl/core/iag_pipe.sv
rtl/core/im2col_address_generator.sv
bench/im2col_address_generator_tb.sv
